// ===== rtl/ohlc_pft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ohlc_pft_pkg;

  localparam int PRICE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int POS_W         = FRACTION_BITS + 2;

  localparam logic [1:0] ORDER_AUTO = 2'd0;
  localparam logic [1:0] ORDER_HIGH = 2'd1;
  localparam logic [1:0] ORDER_LOW  = 2'd2;

  localparam logic REG_PATH_ORDER = 1'b0;

  typedef logic signed [PRICE_BITS-1:0] price_t;
  typedef logic [PRICE_BITS-1:0]        mag_t;
  typedef logic [FRACTION_BITS:0]       quo_t;
  typedef logic [POS_W-1:0]             pos_t;

  typedef struct packed {
    price_t bar_open;
    price_t bar_high;
    price_t bar_low;
    price_t bar_close;
    price_t level;
    logic   level_valid;
    logic   fill_after_path;
  } in_t;

  typedef struct packed {
    logic touched;
    pos_t position;
    logic high_leg_first;
    logic mask_valid;
    logic skip_high_leg;
    logic skip_low_leg;
  } out_t;

  typedef struct packed {
    price_t p0;
    price_t p1;
    price_t p2;
    price_t p3;
    price_t level;
    logic   level_valid;
    logic   hi_first;
    logic   after;
  } ord_t;

  typedef struct packed {
    logic       touched;
    logic [1:0] seg;
    logic       zero;
    logic       hi_first;
    logic       after;
  } side_t;

  function automatic mag_t abs_diff(input price_t a, input price_t b);
    logic [PRICE_BITS:0] d;
    d = {a[PRICE_BITS-1], a} - {b[PRICE_BITS-1], b};
    if (d[PRICE_BITS]) begin
      d = -d;
    end
    return d[PRICE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ohlc_path_first_touch.sv =====
// First touch of a price level on a bar path (open, extreme, extreme, close).
// Input channel in_valid/in_stall/in_data carries one bar, a level and flags;
// output channel out_valid/out_stall/out_data carries one result per transfer.
// Both use valid/stall: a transfer happens on a clock edge with valid high and
// stall low. The APB port holds path_order at address 0 (auto, high first,
// low first); write it only while no transfer is in flight.
// From input transfer to out_valid: two stages pick the leg order, three find
// the segment and the integer quotient bit, one restoring divider step per
// fraction bit, and one output register. Throughput is one transfer per cycle
// while the output is not stalled.
// When out_stall is high while out_valid is high the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
// Synchronous active-low reset clears all stage valid bits and sets path_order
// to auto; the block takes input in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module ohlc_path_first_touch (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ohlc_pft_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ohlc_pft_pkg::out_t  out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int F = ohlc_pft_pkg::FRACTION_BITS;

  logic       en;
  logic [1:0] path_order_r;

  logic                ord_v;
  ohlc_pft_pkg::ord_t  ord_d;

  logic                div_v    [F+1];
  ohlc_pft_pkg::side_t div_side [F+1];
  ohlc_pft_pkg::mag_t  div_rem  [F+1];
  ohlc_pft_pkg::mag_t  div_den  [F+1];
  ohlc_pft_pkg::quo_t  div_quo  [F+1];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ohlc_pft_pkg::REG_PATH_ORDER) ?
                  {30'd0, path_order_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_order_r <= ohlc_pft_pkg::ORDER_AUTO;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ohlc_pft_pkg::REG_PATH_ORDER) begin
      path_order_r <= pwdata[1:0];
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ohlc_pft_order u_order (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (in_valid),
    .in_d       (in_data),
    .path_order (path_order_r),
    .out_v      (ord_v),
    .out_d      (ord_d)
  );

  ohlc_pft_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (ord_v),
    .in_d     (ord_d),
    .out_v    (div_v[0]),
    .out_side (div_side[0]),
    .out_rem  (div_rem[0]),
    .out_den  (div_den[0]),
    .out_quo  (div_quo[0])
  );

  for (genvar k = 0; k < F; k++) begin : g_div
    ohlc_pft_div_stage u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (div_v[k]),
      .in_side  (div_side[k]),
      .in_rem   (div_rem[k]),
      .in_den   (div_den[k]),
      .in_quo   (div_quo[k]),
      .out_v    (div_v[k+1]),
      .out_side (div_side[k+1]),
      .out_rem  (div_rem[k+1]),
      .out_den  (div_den[k+1]),
      .out_quo  (div_quo[k+1])
    );
  end

  ohlc_pft_final u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (div_v[F]),
    .in_side (div_side[F]),
    .in_quo  (div_quo[F]),
    .out_v   (out_valid),
    .out_d   (out_data)
  );

`ifndef SYNTHESIS
  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_touch_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.touched |-> out_data.position == '0)
    else $error("position set without touch");

  a_touch_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.touched |-> out_data.mask_valid)
    else $error("touch without mask");

  a_skip_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.mask_valid |->
      !out_data.skip_high_leg && !out_data.skip_low_leg)
    else $error("skip flag without mask");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/ohlc_pft_order.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ohlc_pft_order (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_v,
  input  ohlc_pft_pkg::in_t   in_d,
  input  wire  [1:0]          path_order,
  output logic                out_v,
  output ohlc_pft_pkg::ord_t  out_d
);

  logic               v1_r;
  ohlc_pft_pkg::in_t  d1_r;
  ohlc_pft_pkg::mag_t d_hi_r;
  ohlc_pft_pkg::mag_t d_lo_r;
  logic               v2_r;
  ohlc_pft_pkg::ord_t ord_r;
  ohlc_pft_pkg::ord_t ord_nxt;
  logic               hf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= in_d;
      d_hi_r <= ohlc_pft_pkg::abs_diff(in_d.bar_high, in_d.bar_open);
      d_lo_r <= ohlc_pft_pkg::abs_diff(in_d.bar_open, in_d.bar_low);
      ord_r  <= ord_nxt;
    end
  end

  always_comb begin
    case (path_order)
      ohlc_pft_pkg::ORDER_HIGH: hf = 1'b1;
      ohlc_pft_pkg::ORDER_LOW:  hf = 1'b0;
      default:                  hf = d_hi_r < d_lo_r;
    endcase
    ord_nxt.p0          = d1_r.bar_open;
    ord_nxt.p1          = hf ? d1_r.bar_high : d1_r.bar_low;
    ord_nxt.p2          = hf ? d1_r.bar_low : d1_r.bar_high;
    ord_nxt.p3          = d1_r.bar_close;
    ord_nxt.level       = d1_r.level;
    ord_nxt.level_valid = d1_r.level_valid;
    ord_nxt.hi_first    = hf;
    ord_nxt.after       = d1_r.fill_after_path;
  end

  assign out_v = v2_r;
  assign out_d = ord_r;

endmodule
`default_nettype wire

// ===== rtl/ohlc_pft_seg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ohlc_pft_seg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_v,
  input  ohlc_pft_pkg::ord_t   in_d,
  output logic                 out_v,
  output ohlc_pft_pkg::side_t  out_side,
  output ohlc_pft_pkg::mag_t   out_rem,
  output ohlc_pft_pkg::mag_t   out_den,
  output ohlc_pft_pkg::quo_t   out_quo
);

  localparam int P = ohlc_pft_pkg::PRICE_BITS;

  // segment compare stage
  logic                v3_r;
  logic [2:0]          hit_r;
  logic [2:0]          zero_r;
  ohlc_pft_pkg::mag_t  num_r [3];
  ohlc_pft_pkg::mag_t  den_r [3];
  logic                hf3_r;
  logic                after3_r;
  logic [2:0]          hit_nxt;
  logic [2:0]          zero_nxt;
  ohlc_pft_pkg::mag_t  num_nxt [3];
  ohlc_pft_pkg::mag_t  den_nxt [3];
  ohlc_pft_pkg::price_t sa [3];
  ohlc_pft_pkg::price_t sb [3];

  // first-hit select stage
  logic                v4_r;
  ohlc_pft_pkg::side_t side4_r;
  ohlc_pft_pkg::mag_t  num4_r;
  ohlc_pft_pkg::mag_t  den4_r;
  ohlc_pft_pkg::side_t side4_nxt;
  ohlc_pft_pkg::mag_t  num4_nxt;
  ohlc_pft_pkg::mag_t  den4_nxt;

  // integer quotient bit
  logic                v5_r;
  ohlc_pft_pkg::side_t side5_r;
  ohlc_pft_pkg::mag_t  rem5_r;
  ohlc_pft_pkg::mag_t  den5_r;
  logic                q5_r;
  logic [P:0]          diff5;
  logic                ge5;

  always_comb begin
    sa[0] = in_d.p0;
    sb[0] = in_d.p1;
    sa[1] = in_d.p1;
    sb[1] = in_d.p2;
    sa[2] = in_d.p2;
    sb[2] = in_d.p3;
    for (int s = 0; s < 3; s++) begin
      hit_nxt[s]  = in_d.level_valid &&
                    ((in_d.level >= sa[s] && in_d.level <= sb[s]) ||
                     (in_d.level >= sb[s] && in_d.level <= sa[s]));
      zero_nxt[s] = sa[s] == sb[s];
      num_nxt[s]  = ohlc_pft_pkg::abs_diff(in_d.level, sa[s]);
      den_nxt[s]  = ohlc_pft_pkg::abs_diff(sb[s], sa[s]);
    end
  end

  always_comb begin
    side4_nxt.touched  = |hit_r;
    side4_nxt.hi_first = hf3_r;
    side4_nxt.after    = after3_r;
    if (hit_r[0]) begin
      side4_nxt.seg  = 2'd0;
      side4_nxt.zero = zero_r[0];
      num4_nxt       = num_r[0];
      den4_nxt       = den_r[0];
    end else if (hit_r[1]) begin
      side4_nxt.seg  = 2'd1;
      side4_nxt.zero = zero_r[1];
      num4_nxt       = num_r[1];
      den4_nxt       = den_r[1];
    end else begin
      side4_nxt.seg  = 2'd2;
      side4_nxt.zero = zero_r[2];
      num4_nxt       = num_r[2];
      den4_nxt       = den_r[2];
    end
  end

  assign diff5 = {1'b0, num4_r} - {1'b0, den4_r};
  assign ge5   = !diff5[P];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_v;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= hit_nxt;
      zero_r   <= zero_nxt;
      hf3_r    <= in_d.hi_first;
      after3_r <= in_d.after;
      for (int s = 0; s < 3; s++) begin
        num_r[s] <= num_nxt[s];
        den_r[s] <= den_nxt[s];
      end
      side4_r <= side4_nxt;
      num4_r  <= num4_nxt;
      den4_r  <= den4_nxt;
      side5_r <= side4_r;
      den5_r  <= den4_r;
      q5_r    <= ge5;
      rem5_r  <= ge5 ? diff5[P-1:0] : num4_r;
    end
  end

  assign out_v    = v5_r;
  assign out_side = side5_r;
  assign out_rem  = rem5_r;
  assign out_den  = den5_r;
  assign out_quo  = {{ohlc_pft_pkg::FRACTION_BITS{1'b0}}, q5_r};

endmodule
`default_nettype wire

// ===== rtl/ohlc_pft_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ohlc_pft_div_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_v,
  input  ohlc_pft_pkg::side_t  in_side,
  input  ohlc_pft_pkg::mag_t   in_rem,
  input  ohlc_pft_pkg::mag_t   in_den,
  input  ohlc_pft_pkg::quo_t   in_quo,
  output logic                 out_v,
  output ohlc_pft_pkg::side_t  out_side,
  output ohlc_pft_pkg::mag_t   out_rem,
  output ohlc_pft_pkg::mag_t   out_den,
  output ohlc_pft_pkg::quo_t   out_quo
);

  localparam int P = ohlc_pft_pkg::PRICE_BITS;
  localparam int F = ohlc_pft_pkg::FRACTION_BITS;

  logic                v_r;
  ohlc_pft_pkg::side_t side_r;
  ohlc_pft_pkg::mag_t  rem_r;
  ohlc_pft_pkg::mag_t  den_r;
  ohlc_pft_pkg::quo_t  quo_r;
  logic [P:0]          sh;
  logic [P+1:0]        diff;
  logic                ge;

  // one restoring step: shift in a zero, try to subtract
  assign sh   = {in_rem, 1'b0};
  assign diff = {1'b0, sh} - {2'b00, in_den};
  assign ge   = !diff[P+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      den_r  <= in_den;
      quo_r  <= {in_quo[F-1:0], ge};
      rem_r  <= ge ? diff[P-1:0] : sh[P-1:0];
    end
  end

  assign out_v    = v_r;
  assign out_side = side_r;
  assign out_rem  = rem_r;
  assign out_den  = den_r;
  assign out_quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/ohlc_pft_final.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ohlc_pft_final (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_v,
  input  ohlc_pft_pkg::side_t  in_side,
  input  ohlc_pft_pkg::quo_t   in_quo,
  output logic                 out_v,
  output ohlc_pft_pkg::out_t   out_d
);

  localparam int F = ohlc_pft_pkg::FRACTION_BITS;
  localparam int W = ohlc_pft_pkg::POS_W;
  localparam ohlc_pft_pkg::pos_t ONE_POS = W'(1) << F;
  localparam ohlc_pft_pkg::pos_t TWO_POS = W'(2) << F;

  logic               v_r;
  ohlc_pft_pkg::out_t out_r;
  ohlc_pft_pkg::out_t out_nxt;
  ohlc_pft_pkg::quo_t frac;
  ohlc_pft_pkg::pos_t pos;
  ohlc_pft_pkg::pos_t hpos;
  ohlc_pft_pkg::pos_t lpos;

  always_comb begin
    frac = in_side.zero ? '0 : in_quo;
    pos  = in_side.touched ? ({in_side.seg, {F{1'b0}}} + {1'b0, frac}) : '0;
    hpos = in_side.hi_first ? ONE_POS : TWO_POS;
    lpos = in_side.hi_first ? TWO_POS : ONE_POS;
    out_nxt.touched        = in_side.touched;
    out_nxt.position       = pos;
    out_nxt.high_leg_first = in_side.hi_first;
    out_nxt.mask_valid     = in_side.after || in_side.touched;
    out_nxt.skip_high_leg  = in_side.after || (in_side.touched && hpos < pos);
    out_nxt.skip_low_leg   = in_side.after || (in_side.touched && lpos < pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = out_r;

endmodule
`default_nettype wire
